[design/fir_121_tap_sample_filter_assert.svh]
// Assertion macros shared by the filter's checker.
`ifndef FIR_121_TAP_SAMPLE_FILTER_ASSERT_SVH
`define FIR_121_TAP_SAMPLE_FILTER_ASSERT_SVH

// Clocked assertion, disabled while reset is asserted.
`define FIR121_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("fir121 checker: assertion failed");

// Clocked assertion that also holds during reset.
`define FIR121_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fir121 checker: assertion failed");

`endif

[design/fir121_pkg.sv]
// Shared types, constants and the coefficient table of the 121-tap filter.
`default_nettype none

package fir121_pkg;

  localparam int TableLen   = 121;
  localparam int OffsetRst  = 16384;
  localparam int RoundBias  = 4096;
  localparam int RoundShift = 13;
  localparam int OutMax     = 524287;
  localparam int OutMin     = -524288;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain,
    StDone
  } fir_state_e;

  // Controls from the sequencer to the delay-line memory.
  typedef struct packed {
    logic start;  // new item: rewind read pointer, load live count
    logic step;   // read one past sample, move to the next older one
    logic wr;     // write the current sample and advance
  } dl_ctrl_t;

  // Symmetric low-pass taps, Q1.15.
  localparam logic signed [15:0] CoefRom [TableLen] = '{
    16'sd133,   -16'sd12,   -16'sd36,   -16'sd78,   -16'sd134,
    -16'sd192,  -16'sd235,  -16'sd240,  -16'sd192,  -16'sd86,
    16'sd60,    16'sd216,   16'sd345,   16'sd412,   16'sd402,
    16'sd318,   16'sd183,   16'sd33,    -16'sd95,   -16'sd172,
    -16'sd187,  -16'sd147,  -16'sd75,   -16'sd7,    16'sd25,
    -16'sd3,    -16'sd97,   -16'sd237,  -16'sd384,  -16'sd490,
    -16'sd509,  -16'sd417,  -16'sd220,  16'sd44,    16'sd314,
    16'sd521,   16'sd614,   16'sd573,   16'sd423,   16'sd223,
    16'sd52,    -16'sd18,   16'sd53,    16'sd251,   16'sd515,
    16'sd742,   16'sd817,   16'sd652,   16'sd211,   -16'sd464,
    -16'sd1260, -16'sd2003, -16'sd2506, -16'sd2607, -16'sd2221,
    -16'sd1363, -16'sd159,  16'sd1179,  16'sd2393,  16'sd3238,
    16'sd3540,
    16'sd3238,  16'sd2393,  16'sd1179,  -16'sd159,  -16'sd1363,
    -16'sd2221, -16'sd2607, -16'sd2506, -16'sd2003, -16'sd1260,
    -16'sd464,  16'sd211,   16'sd652,   16'sd817,   16'sd742,
    16'sd515,   16'sd251,   16'sd53,    -16'sd18,   16'sd52,
    16'sd223,   16'sd423,   16'sd573,   16'sd614,   16'sd521,
    16'sd314,   16'sd44,    -16'sd220,  -16'sd417,  -16'sd509,
    -16'sd490,  -16'sd384,  -16'sd237,  -16'sd97,   -16'sd3,
    16'sd25,    -16'sd7,    -16'sd75,   -16'sd147,  -16'sd187,
    -16'sd172,  -16'sd95,   16'sd33,    16'sd183,   16'sd318,
    16'sd402,   16'sd412,   16'sd345,   16'sd216,   16'sd60,
    -16'sd86,   -16'sd192,  -16'sd240,  -16'sd235,  -16'sd192,
    -16'sd134,  -16'sd78,   -16'sd36,   -16'sd12,   16'sd133
  };

  // Taps past the end of the table read as zero.
  function automatic logic signed [15:0] tap_coef(input logic [7:0] idx);
    logic signed [15:0] c;
    if (idx < 8'(TableLen)) begin
      c = CoefRom[idx[6:0]];
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[design/fir121_dline.sv]
// Circular delay-line memory with fill count for the 121-tap filter.
`default_nettype none

module fir121_dline #(
  parameter int unsigned DEPTH = 120
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fir121_pkg::dl_ctrl_t ctrl_i,
  input  wire logic signed [15:0]   wr_data_i,
  output logic signed [15:0]        rd_data_o,
  output logic                      rd_live_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic signed [15:0] mem [DEPTH];

  logic [AW-1:0]      wp_q, wp_d;
  logic [AW-1:0]      rp_q, rp_d;
  logic [FW-1:0]      fill_q, fill_d;
  logic [FW-1:0]      rem_q, rem_d;
  logic               live_q, live_d;
  logic signed [15:0] rd_data_q;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    if (p == '0) begin
      r = AW'(DEPTH - 1);
    end else begin
      r = p - AW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wp_d   = wp_q;
    rp_d   = rp_q;
    fill_d = fill_q;
    rem_d  = rem_q;
    live_d = live_q;
    if (ctrl_i.start) begin
      rp_d  = ptr_dec(wp_q);
      rem_d = fill_q;
    end else if (ctrl_i.step) begin
      rp_d   = ptr_dec(rp_q);
      live_d = (rem_q != '0);
      if (rem_q != '0) begin
        rem_d = rem_q - FW'(1);
      end
    end
    if (ctrl_i.wr) begin
      wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
      if (fill_q != FW'(DEPTH)) begin
        fill_d = fill_q + FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      fill_q <= '0;
      rem_q  <= '0;
      live_q <= 1'b0;
    end else begin
      wp_q   <= wp_d;
      rp_q   <= rp_d;
      fill_q <= fill_d;
      rem_q  <= rem_d;
      live_q <= live_d;
    end
  end

  // Read-first port; reads and writes never target the same item's slot at once.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem[wp_q] <= wr_data_i;
    end
    if (ctrl_i.step) begin
      rd_data_q <= mem[rp_q];
    end
  end

  assign rd_data_o = rd_data_q;
  assign rd_live_o = live_q;

endmodule

`default_nettype wire

[design/fir_121_tap_sample_filter.sv]
// Top level of the 121-tap FIR sample filter: sequencer, MAC datapath, output register.
// One item at a time: no new item is taken until the current one's result is loaded into
// the output register, set by the single multiply-accumulate unit that takes one tap per
// cycle through the delay-line memory's one read port.
// A finished result waits in the output register while the next item is taken.
// Reset: offset register to 16384, output empty; the delay line reads as zero
// through its fill count, so no clearing pass runs.
`default_nettype none

module fir_121_tap_sample_filter #(
  parameter int unsigned TAPS = 121
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration
  input  wire logic               cfg_we_i,
  input  wire logic [14:0]        cfg_wdata_i,
  // input channel
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [14:0]        sample_i,
  // output channel
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [19:0]      filtered_o
);

  localparam int unsigned DEPTH = TAPS - 1;
  localparam int unsigned CW    = $clog2(TAPS);
  localparam int unsigned AccW  = 32 + $clog2(TAPS);

  localparam logic signed [AccW-1:0] SatHi = AccW'(fir121_pkg::OutMax);
  localparam logic signed [AccW-1:0] SatLo = AccW'(fir121_pkg::OutMin);

  // ---------------------------------------------------------------------------
  // Offset register
  // ---------------------------------------------------------------------------
  logic [14:0] offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 15'(fir121_pkg::OffsetRst);
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  fir121_pkg::fir_state_e state_q, state_d;
  fir121_pkg::dl_ctrl_t   dl_ctrl;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          issue;       // one tap enters the MAC pipe this cycle
  logic          issue_last;
  logic          out_load;

  // pipe stage 1: coefficient and memory read
  logic          v1_q, last1_q, selx1_q;
  // pipe stage 2: product
  logic          v2_q, last2_q;

  logic signed [15:0] x_q;
  logic signed [15:0] coef_q;
  logic signed [15:0] opnd;
  logic signed [31:0] prod_q;
  logic signed [AccW-1:0] acc_q;
  logic signed [AccW-1:0] rnd;
  logic signed [AccW-1:0] shifted;
  logic signed [19:0]     sat;
  logic signed [19:0]     filtered_q;
  logic                   out_valid_q, out_valid_d;

  logic signed [15:0] dl_rd_data;
  logic               dl_rd_live;
  logic [15:0]        diff;

  assign accept     = in_valid_i && (state_q == fir121_pkg::StIdle);
  assign in_stall_o = (state_q != fir121_pkg::StIdle);
  assign issue_last = (cnt_q == CW'(TAPS - 1));

  // offset removal; the difference always fits 16 bits
  assign diff = {1'b0, sample_i} - {1'b0, offset_q};

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    issue    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      fir121_pkg::StIdle: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = fir121_pkg::StRun;
        end
      end
      fir121_pkg::StRun: begin
        issue = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (issue_last) begin
          state_d = fir121_pkg::StDrain;
        end
      end
      fir121_pkg::StDrain: begin
        // final product lands in the accumulator at this edge
        if (last2_q) begin
          state_d = fir121_pkg::StDone;
        end
      end
      fir121_pkg::StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = fir121_pkg::StIdle;
        end
      end
      default: begin
        state_d = fir121_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fir121_pkg::StIdle;
      cnt_q   <= '0;
      v1_q    <= 1'b0;
      last1_q <= 1'b0;
      selx1_q <= 1'b0;
      v2_q    <= 1'b0;
      last2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      v1_q    <= issue;
      last1_q <= issue && issue_last;
      selx1_q <= issue && (cnt_q == '0);
      v2_q    <= v1_q;
      last2_q <= last1_q;
    end
  end

  // Tap 0 uses the current sample; taps 1.. read past samples, newest first.
  // The current sample goes into memory only after the oldest slot was read.
  assign dl_ctrl.start = accept;
  assign dl_ctrl.step  = issue && (cnt_q != '0);
  assign dl_ctrl.wr    = v1_q && last1_q;

  fir121_dline #(
    .DEPTH(DEPTH)
  ) u_dline (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (dl_ctrl),
    .wr_data_i (x_q),
    .rd_data_o (dl_rd_data),
    .rd_live_o (dl_rd_live)
  );

  // ---------------------------------------------------------------------------
  // MAC datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= signed'(diff);
    end
    if (issue) begin
      coef_q <= fir121_pkg::tap_coef(8'(cnt_q));
    end
    if (v1_q) begin
      prod_q <= coef_q * opnd;
    end
  end

  // entries never written since reset count as zero
  always_comb begin
    if (selx1_q) begin
      opnd = x_q;
    end else if (dl_rd_live) begin
      opnd = dl_rd_data;
    end else begin
      opnd = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
  end

  // Q2.30 -> Q3.17, round half up (floor after bias), then clamp
  assign rnd     = acc_q + AccW'(fir121_pkg::RoundBias);
  assign shifted = rnd >>> fir121_pkg::RoundShift;

  always_comb begin
    if (shifted > SatHi) begin
      sat = 20'(SatHi);
    end else if (shifted < SatLo) begin
      sat = 20'(SatLo);
    end else begin
      sat = 20'(shifted);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;

endmodule

`default_nettype wire

[design/fir121_checker.sv]
// Port-level checker for the 121-tap filter, bound to the top level.
`default_nettype none

`include "fir_121_tap_sample_filter_assert.svh"

module fir121_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [19:0] filtered_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result holds
  `FIR121_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(filtered_o))

  // one item at a time: the block is busy right after it takes an item
  `FIR121_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> in_stall_o)

  // a new result only comes out of an item in work
  `FIR121_ASSERT(a_result_from_work, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o))

  // finishing an item always leaves a result in the output register
  `FIR121_ASSERT(a_done_has_result, clk_i, rst_ni, $fell(in_stall_o) |-> out_valid_o)

endmodule

bind fir_121_tap_sample_filter fir121_checker u_fir121_checker (.*);

`default_nettype wire
